FILE: rtl/top_k_score_selector_macros.svh
// Assertion macros for the top-k score selector.
`ifndef TOP_K_SCORE_SELECTOR_MACROS_SVH
`define TOP_K_SCORE_SELECTOR_MACROS_SVH

`ifndef SYNTH
`define TKSEL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TKSEL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TKSEL_ASSERT(label, clk, rst, prop, msg)
`define TKSEL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: rtl/tksel_pkg.sv
package tksel_pkg;

  localparam int SCORE_W = 32;
  localparam int ID_W    = 32;
  localparam int KEEP_W  = 7;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd10;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic gt;
    logic le;
  } cell_flags_t;

  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_SHIFT   = 2'd3
  } op_t;

endpackage

FILE: rtl/tksel_in_if.sv
interface tksel_in_if;
  logic                         valid;
  logic                         ready;
  logic [tksel_pkg::SCORE_W-1:0] score;
  logic [tksel_pkg::ID_W-1:0]    item_id;
  logic                         last_item;

  modport source (output valid, output score, output item_id, output last_item,
                  input ready);
  modport sink (input valid, input score, input item_id, input last_item,
                output ready);
endinterface

FILE: rtl/tksel_out_if.sv
interface tksel_out_if;
  logic                         valid;
  logic                         ready;
  logic [tksel_pkg::SCORE_W-1:0] out_score;
  logic [tksel_pkg::ID_W-1:0]    out_id;
  logic                         out_last;

  modport source (output valid, output out_score, output out_id, output out_last,
                  input ready);
  modport sink (input valid, input out_score, input out_id, input out_last,
                output ready);
endinterface

FILE: rtl/tksel_cell.sv
module tksel_cell (
  input  logic                   clk,
  input  tksel_pkg::op_t         op,
  input  logic                   valid,
  input  tksel_pkg::entry_t      new_entry,
  input  tksel_pkg::entry_t      left_entry,
  input  tksel_pkg::cell_flags_t left_flags,
  input  tksel_pkg::entry_t      right_entry,
  input  tksel_pkg::cell_flags_t right_flags,
  output tksel_pkg::entry_t      entry,
  output tksel_pkg::cell_flags_t flags
);

  tksel_pkg::entry_t entry_next;

  always_comb begin
    flags.valid = valid;
    flags.gt    = valid && (entry.score > new_entry.score);
    flags.le    = valid && (entry.score <= new_entry.score);
  end

  always_comb begin
    entry_next = entry;
    case (op)
      tksel_pkg::OP_INSERT: begin
        if (flags.gt || (!valid && left_flags.valid)) begin
          entry_next = left_flags.gt ? left_entry : new_entry;
        end
      end
      tksel_pkg::OP_REPLACE: begin
        if (right_flags.le) begin
          entry_next = right_entry;
        end else if (flags.le) begin
          entry_next = new_entry;
        end
      end
      tksel_pkg::OP_SHIFT: begin
        entry_next = right_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

FILE: rtl/top_k_score_selector.sv
// Keeps the keep_count highest-scoring items of a stream (ties broken by arrival:
// an item that only ties the lowest kept score is dropped, and among kept ties
// the earliest is evicted first) in a sorted chain of MAX_KEEP cells and
// accepts one item per cycle while collecting. An item marked last is folded
// in like any other; the block then stops accepting and emits the kept entries
// smallest score first, one per cycle as the result side takes them, with
// out_last on the final one. The input stays blocked while the kept entries
// drain, and longer while the result side stalls; the drain rate is set by
// the single output register feeding from the head cell of the chain.
`include "top_k_score_selector_macros.svh"

module top_k_score_selector #(
  parameter int MAX_KEEP = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  tksel_in_if.sink                      items,
  tksel_out_if.source                   results,
  input  logic                          cfg_we,
  input  logic [tksel_pkg::KEEP_W-1:0]  cfg_data
);

  localparam int FW = $clog2(MAX_KEEP + 1);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } state_t;

  state_t                      state, state_next;
  logic [FW-1:0]               fill, fill_next;
  logic [tksel_pkg::KEEP_W-1:0] keep_count;
  logic [FW-1:0]               keep_eff;
  logic                        out_valid;
  tksel_pkg::entry_t           out_entry;
  logic                        out_last;
  logic                        accept;
  logic                        load;
  tksel_pkg::op_t              op;
  tksel_pkg::entry_t           new_entry;
  tksel_pkg::entry_t           entries [MAX_KEEP];
  tksel_pkg::cell_flags_t      flags   [MAX_KEEP];

  assign new_entry.score = items.score;
  assign new_entry.id    = items.item_id;

  assign items.ready = (state == ST_COLLECT);
  assign accept      = items.valid && items.ready;

  assign keep_eff = ({1'b0, keep_count} > (tksel_pkg::KEEP_W + 1)'(MAX_KEEP))
                    ? FW'(MAX_KEEP) : FW'(keep_count);

  always_comb begin
    op         = tksel_pkg::OP_HOLD;
    fill_next  = fill;
    state_next = state;
    load       = 1'b0;
    case (state)
      ST_COLLECT: begin
        if (accept) begin
          if (fill < keep_eff) begin
            op        = tksel_pkg::OP_INSERT;
            fill_next = fill + FW'(1);
          end else if ((fill != '0) && (entries[0].score < items.score)) begin
            op = tksel_pkg::OP_REPLACE;
          end
          if (items.last_item) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (fill == '0) begin
          state_next = ST_COLLECT;
        end else if (!out_valid || results.ready) begin
          load      = 1'b1;
          op        = tksel_pkg::OP_SHIFT;
          fill_next = fill - FW'(1);
          if (fill == FW'(1)) begin
            state_next = ST_COLLECT;
          end
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    tksel_pkg::entry_t      left_entry, right_entry;
    tksel_pkg::cell_flags_t left_flags, right_flags;

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_flags = '{valid: 1'b1, gt: 1'b0, le: 1'b0};
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_flags = flags[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign right_entry = '0;
      assign right_flags = '0;
    end else begin : g_mid
      assign right_entry = entries[i+1];
      assign right_flags = flags[i+1];
    end

    tksel_cell u_cell (
      .clk         (clk),
      .op          (op),
      .valid       (FW'(i) < fill),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_flags  (left_flags),
      .right_entry (right_entry),
      .right_flags (right_flags),
      .entry       (entries[i]),
      .flags       (flags[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      fill       <= '0;
      keep_count <= tksel_pkg::KEEP_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_we) begin
        keep_count <= cfg_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_entry <= entries[0];
      out_last  <= (fill == FW'(1));
    end
  end

  assign results.valid     = out_valid;
  assign results.out_score = out_entry.score;
  assign results.out_id    = out_entry.id;
  assign results.out_last  = out_last;

  `TKSEL_ASSERT(a_fill_bound, clk, rst, fill <= FW'(MAX_KEEP), "fill above chain depth")
  `TKSEL_ASSERT(a_fill_grow, clk, rst, accept |=> (fill == $past(fill)) || (fill == $past(fill) + FW'(1)), "fill grew by more than one")
  `TKSEL_ASSERT(a_drain_end, clk, rst, (load && (fill == FW'(1))) |=> (fill == '0) && (state == ST_COLLECT) && out_last, "drain did not close on final entry")

endmodule
